FILE: design/assert_macros.svh
// Assertion macros shared by the text command line decoder RTL.
// Needs signals named clk and rst in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: design/tcld_pkg.sv
// Shared types, character codes and sizes for the text command line decoder.
// No dependencies.
`default_nettype none

package tcld_pkg;

  // Period width and derived sizes
  localparam int PERIOD_BITS = 16;
  localparam int ACC_W       = PERIOD_BITS + 1;
  localparam int MAC_W       = ACC_W + 4;
  localparam int OUT_PER_W   = 16;
  localparam int WIDE_W      = (PERIOD_BITS > OUT_PER_W) ? PERIOD_BITS : OUT_PER_W;
  localparam int HEAD_LEN    = 7;
  localparam int CNT_W       = 3;

  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;
  localparam logic [PERIOD_BITS-1:0] PERIOD_ONE = PERIOD_BITS'(1);
  localparam logic [ACC_W-1:0]       ACC_SAT    = ACC_W'(1) << PERIOD_BITS;
  localparam logic [CNT_W-1:0]       CNT_FULL   = CNT_W'(HEAD_LEN);

  // Character codes
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;

  // Number parser phase
  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } num_phase_t;

  // Command outcome codes
  typedef enum logic [3:0] {
    RES_SCALE_OK  = 4'd0,
    RES_SCALE_BAD = 4'd1,
    RES_PERIOD_OK = 4'd2,
    RES_PERIOD_CL = 4'd3,
    RES_STOP      = 4'd4,
    RES_START     = 4'd5,
    RES_ST_OTHER  = 4'd6,
    RES_LOG       = 4'd7,
    RES_OFF       = 4'd8,
    RES_UNKNOWN   = 4'd9
  } cmd_result_t;

  // Collected line state handed to the classifier
  typedef struct packed {
    logic [CNT_W-1:0]               count;
    logic [HEAD_LEN-1:0][7:0]       head;
    logic [ACC_W-1:0]               accum;
    logic                           negative;
  } line_info_t;

  // Persistent settings
  typedef struct packed {
    logic                   celsius;
    logic [PERIOD_BITS-1:0] period;
    logic                   stopped;
    logic                   off;
  } settings_t;

endpackage

`default_nettype wire

FILE: design/text_command_line_decoder_top.sv
// Top level of the text command line decoder: input register, line collector,
// classifier and result register. Depends on tcld_pkg, tcld_line, tcld_cmd.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------
//   input    | in_valid / in_stall | rx_byte
//   result   | out_valid/out_stall | cmd_result, echo_line, celsius_now,
//            |                     | period_now, stopped_now, off_requested
//
// One byte per cycle while no newline waits on the result register; a byte is
// captured in the input register and consumed from it, and a newline's result
// is then captured in the result register. Only a newline waits on a full,
// stalled result register; other bytes pass through. Synchronous reset clears
// line state and returns settings to Fahrenheit, period 1, reporting on, no shutdown.
`default_nettype none

module text_command_line_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       cmd_result,
  output logic             echo_line,
  output logic             celsius_now,
  output logic [15:0]      period_now,
  output logic             stopped_now,
  output logic             off_requested
);
  import tcld_pkg::*;
  `include "assert_macros.svh"

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_nl;
  logic        s1_go;
  logic        in_take;
  logic        out_take;
  logic        apply;

  line_info_t  info;
  cmd_result_t code;
  logic        echo;
  settings_t   settings_next;
  logic [WIDE_W-1:0] period_wide;

  // Handshake: a newline moves on only when the result register has room
  assign s1_nl    = (s1_byte == CH_NL);
  assign s1_go    = s1_valid && (!s1_nl || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign apply    = s1_go && s1_nl;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= rx_byte;
    end
  end

  tcld_line u_line (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_go),
    .rx_char (s1_byte),
    .info    (info)
  );

  tcld_cmd u_cmd (
    .clk           (clk),
    .rst           (rst),
    .apply         (apply),
    .info          (info),
    .code          (code),
    .echo          (echo),
    .settings_next (settings_next)
  );

  assign period_wide = WIDE_W'(settings_next.period);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      cmd_result    <= code;
      echo_line     <= echo;
      celsius_now   <= settings_next.celsius;
      period_now    <= period_wide[OUT_PER_W-1:0];
      stopped_now   <= settings_next.stopped;
      off_requested <= settings_next.off;
    end
  end

  `ASSERT_CLK(a_stall_needs_byte, in_stall |-> (s1_valid && s1_nl), "stall without a held newline")
  `ASSERT_CLK(a_result_follows, apply |=> out_valid, "newline consumed without a result")

endmodule

`default_nettype wire

FILE: design/tcld_line.sv
// Line collector: head characters, character count and period number parser.
// Depends on tcld_pkg and assert_macros.svh.
`default_nettype none

module tcld_line (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        rx_char,
  output tcld_pkg::line_info_t   info
);
  import tcld_pkg::*;
  `include "assert_macros.svh"

  logic [CNT_W-1:0]         count;
  logic [HEAD_LEN-1:0][7:0] head;
  logic [ACC_W-1:0]         accum;
  logic [ACC_W-1:0]         accum_next;
  logic                     negative;
  logic                     negative_next;
  num_phase_t               phase;
  num_phase_t               phase_next;

  logic             is_nl;
  logic             is_ws;
  logic             is_sign;
  logic             is_digit;
  logic             in_number;
  logic [MAC_W-1:0] mac;

  assign is_nl     = (rx_char == CH_NL);
  assign is_ws     = (rx_char == CH_SPACE) || (rx_char == CH_TAB) || (rx_char == CH_VT) ||
                     (rx_char == CH_FF) || (rx_char == CH_CR);
  assign is_sign   = (rx_char == CH_PLUS) || (rx_char == CH_MINUS);
  assign is_digit  = (rx_char >= CH_0) && (rx_char <= CH_9);
  assign in_number = step && !is_nl && (count == CNT_FULL);

  // accum * 10 + digit
  assign mac = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} + MAC_W'(rx_char - CH_0);

  // Parser next state
  always_comb begin
    phase_next = phase;
    if (in_number) begin
      unique case (phase)
        PH_SKIP: begin
          if (is_ws) begin
            phase_next = PH_SKIP;
          end else if (is_sign || is_digit) begin
            phase_next = PH_DIGITS;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (!is_digit) begin
            phase_next = PH_DONE;
          end
        end
        PH_DONE:   phase_next = PH_DONE;
        default:   phase_next = PH_DONE;
      endcase
    end
  end

  // Parser outputs: sign and saturating magnitude
  always_comb begin
    accum_next    = accum;
    negative_next = negative;
    if (in_number) begin
      if (phase == PH_SKIP && rx_char == CH_MINUS) begin
        negative_next = 1'b1;
      end
      if ((phase == PH_SKIP && !is_ws && !is_sign && is_digit) ||
          (phase == PH_DIGITS && is_digit)) begin
        accum_next = (mac > MAC_W'(ACC_SAT)) ? ACC_SAT : mac[ACC_W-1:0];
      end
    end
  end

  // Line registers; newline clears the line
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      head     <= '0;
      accum    <= '0;
      negative <= 1'b0;
      phase    <= PH_SKIP;
    end else if (step) begin
      if (is_nl) begin
        count    <= '0;
        head     <= '0;
        accum    <= '0;
        negative <= 1'b0;
        phase    <= PH_SKIP;
      end else begin
        if (count != CNT_FULL) begin
          head[count[CNT_W-1:0]] <= rx_char;
          count                  <= count + CNT_W'(1);
        end
        accum    <= accum_next;
        negative <= negative_next;
        phase    <= phase_next;
      end
    end
  end

  assign info.count    = count;
  assign info.head     = head;
  assign info.accum    = accum;
  assign info.negative = negative;

  // Number parsing only starts once the head is full
  `ASSERT_CLK(a_head_first, count != CNT_FULL |-> phase == PH_SKIP && accum == '0, "early parse")

endmodule

`default_nettype wire

FILE: design/tcld_cmd.sv
// Command classifier and settings registers (scale, period, stop, off).
// Depends on tcld_pkg and assert_macros.svh.
`default_nettype none

module tcld_cmd (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               apply,
  input  wire tcld_pkg::line_info_t info,
  output tcld_pkg::cmd_result_t   code,
  output logic                    echo,
  output tcld_pkg::settings_t     settings_next
);
  import tcld_pkg::*;
  `include "assert_macros.svh"

  settings_t settings;

  logic [7:0] h0, h1, h2, h3, h4, h5, h6;
  logic       len3, len4, len5, len7;
  logic       is_scale, is_period, is_st, is_log, is_off;

  assign h0 = info.head[0];
  assign h1 = info.head[1];
  assign h2 = info.head[2];
  assign h3 = info.head[3];
  assign h4 = info.head[4];
  assign h5 = info.head[5];
  assign h6 = info.head[6];

  assign len3 = (info.count >= CNT_W'(3));
  assign len4 = (info.count >= CNT_W'(4));
  assign len5 = (info.count >= CNT_W'(5));
  assign len7 = (info.count == CNT_FULL);

  // Prefix matches
  assign is_scale  = len7 && h0 == CH_S && h1 == CH_C && h2 == CH_A && h3 == CH_L &&
                     h4 == CH_E && h5 == CH_EQ;
  assign is_period = len7 && h0 == CH_P && h1 == CH_E && h2 == CH_R && h3 == CH_I &&
                     h4 == CH_O && h5 == CH_D && h6 == CH_EQ;
  assign is_st     = len4 && h0 == CH_S && h1 == CH_T;
  assign is_log    = len3 && h0 == CH_L && h1 == CH_O && h2 == CH_G;
  assign is_off    = len3 && h0 == CH_O && h1 == CH_F && h2 == CH_F;

  // Classify the line and work out the settings after it
  always_comb begin
    settings_next = settings;
    code          = RES_UNKNOWN;
    echo          = 1'b1;
    priority if (is_scale) begin
      if (h6 == CH_F) begin
        settings_next.celsius = 1'b0;
        code                  = RES_SCALE_OK;
      end else if (h6 == CH_C) begin
        settings_next.celsius = 1'b1;
        code                  = RES_SCALE_OK;
      end else begin
        code = RES_SCALE_BAD;
        echo = 1'b0;
      end
    end else if (is_period) begin
      if (info.negative || info.accum == '0) begin
        settings_next.period = PERIOD_ONE;
        code                 = RES_PERIOD_CL;
      end else if (info.accum > ACC_W'(PERIOD_MAX)) begin
        settings_next.period = PERIOD_MAX;
        code                 = RES_PERIOD_CL;
      end else begin
        settings_next.period = info.accum[PERIOD_BITS-1:0];
        code                 = RES_PERIOD_OK;
      end
    end else if (is_st) begin
      if (h2 == CH_O && h3 == CH_P) begin
        settings_next.stopped = 1'b1;
        code                  = RES_STOP;
      end else if (len5 && h2 == CH_A && h3 == CH_R && h4 == CH_T) begin
        settings_next.stopped = 1'b0;
        code                  = RES_START;
      end else begin
        code = RES_ST_OTHER;
      end
    end else if (is_log) begin
      code = RES_LOG;
    end else if (is_off) begin
      settings_next.off = 1'b1;
      code              = RES_OFF;
    end else begin
      code = RES_UNKNOWN;
      echo = 1'b0;
    end
  end

  // Settings registers
  always_ff @(posedge clk) begin
    if (rst) begin
      settings.celsius <= 1'b0;
      settings.period  <= PERIOD_ONE;
      settings.stopped <= 1'b0;
      settings.off     <= 1'b0;
    end else if (apply) begin
      settings <= settings_next;
    end
  end

  `ASSERT_NEVER(a_period_nonzero, settings.period == '0, "report period reached zero")
  `ASSERT_CLK(a_off_sticky, settings.off |=> settings.off, "shutdown flag cleared")

endmodule

`default_nettype wire
